// ===== rtl/ptmte_pkg.sv =====
package ptmte_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int CODE_W   = 16;
    localparam int TIME_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZEROCODE = 3'd5;

    // Search token that walks down the row of cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
        logic              match_hit;
        logic              free_hit;
        logic [TIME_W-1:0] min_time;
    } t_scan;

    // Write broadcast from the controller to every cell.
    typedef struct packed {
        logic              en;
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] run_time;
    } t_wr;

endpackage

// ===== rtl/process_table_min_time_evict.sv =====
// Process table with minimum-time replacement, built as a row of cells.
// A new transaction is taken only after the previous result is committed.
// The search token walks the cell row one cell per cycle, followed by the
// decide/write step; the commit waits while an untaken result is held.
// Reset (synchronous, active low) clears every slot to free with zero time.
module process_table_min_time_evict #(
    parameter int TABLE_ENTRIES = ptmte_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_mode,
    input  logic [ptmte_pkg::CODE_W-1:0]        i_process_code,
    input  logic [ptmte_pkg::TIME_W-1:0]        i_run_time,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ptmte_pkg::SLOT_W-1:0]        o_slot,
    output logic [ptmte_pkg::STATUS_W-1:0]      o_status
);
    import ptmte_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // The controller moves through three phases: waiting for a request,
    // letting the search token run down the row, and committing the result.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state;
    t_state            n_state;

    logic              r_mode;
    logic [CODE_W-1:0] r_code;
    logic [TIME_W-1:0] r_time;

    logic              r_match_hit;
    logic              r_free_hit;
    logic [IDX_W-1:0]  r_match_idx;
    logic [IDX_W-1:0]  r_free_idx;
    logic [IDX_W-1:0]  r_min_idx;

    logic                r_out_valid;
    logic [SLOT_W-1:0]   r_slot;
    logic [STATUS_W-1:0] r_status;

    // Token chain: element k feeds cell k, element TABLE_ENTRIES is the tail.
    t_scan             w_tok       [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]  w_match_idx [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]  w_free_idx  [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]  w_min_idx   [TABLE_ENTRIES+1];

    logic              w_accept;
    logic              w_commit;
    t_wr               w_wr;
    logic [IDX_W-1:0]  w_wr_idx;
    logic              w_wr_req;
    logic [IDX_W-1:0]  w_res_idx;
    logic [STATUS_W-1:0] w_res_status;

    // A new transaction is taken only when no search is in flight.
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // The head token is launched straight from the input ports on accept.
    assign w_tok[0] = '{valid: w_accept, code: i_process_code, match_hit: 1'b0,
                        free_hit: 1'b0, min_time: '0};
    assign w_match_idx[0]     = '0;
    assign w_free_idx[0]      = '0;
    assign w_min_idx[0]       = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ptmte_cell #(
            .P_INDEX       (g),
            .IDX_W         (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tok       (w_tok[g]),
            .i_match_idx (w_match_idx[g]),
            .i_free_idx  (w_free_idx[g]),
            .i_min_idx   (w_min_idx[g]),
            .o_tok       (w_tok[g+1]),
            .o_match_idx (w_match_idx[g+1]),
            .o_free_idx  (w_free_idx[g+1]),
            .o_min_idx   (w_min_idx[g+1]),
            .i_wr        (w_wr),
            .i_wr_idx    (w_wr_idx)
        );
    end

    // The result is committed once the output register is free, so a result
    // that is still waiting to be taken is never overwritten.
    assign w_commit = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Decide what the request does with the gathered search results. Deletes
    // clear both the code and the time; a rejected zero code touches nothing.
    always_comb begin
        w_wr_req     = 1'b0;
        w_wr_idx     = '0;
        w_wr.code    = r_code;
        w_wr.run_time = r_time;
        w_res_idx    = '0;
        w_res_status = ST_ZEROCODE;
        if (r_code == '0) begin
            w_res_status = ST_ZEROCODE;
        end else if (r_mode) begin
            if (r_match_hit) begin
                w_wr_req      = 1'b1;
                w_wr_idx      = r_match_idx;
                w_wr.code     = '0;
                w_wr.run_time = '0;
                w_res_idx     = r_match_idx;
                w_res_status  = ST_DELETED;
            end else begin
                w_res_status = ST_NOTFOUND;
            end
        end else if (r_match_hit) begin
            w_wr_req     = 1'b1;
            w_wr_idx     = r_match_idx;
            w_res_idx    = r_match_idx;
            w_res_status = ST_UPDATED;
        end else if (r_free_hit) begin
            w_wr_req     = 1'b1;
            w_wr_idx     = r_free_idx;
            w_res_idx    = r_free_idx;
            w_res_status = ST_INSERTED;
        end else begin
            w_wr_req     = 1'b1;
            w_wr_idx     = r_min_idx;
            w_res_idx    = r_min_idx;
            w_res_status = ST_REPLACED;
        end
        w_wr.en = w_wr_req && w_commit;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok[TABLE_ENTRIES].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and search results are held while the token runs and until
    // the commit; the output register holds the result until it is taken.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_mode;
            r_code <= i_process_code;
            r_time <= i_run_time;
        end
        if ((r_state == S_SCAN) && w_tok[TABLE_ENTRIES].valid) begin
            r_match_hit <= w_tok[TABLE_ENTRIES].match_hit;
            r_free_hit  <= w_tok[TABLE_ENTRIES].free_hit;
            r_match_idx <= w_match_idx[TABLE_ENTRIES];
            r_free_idx  <= w_free_idx[TABLE_ENTRIES];
            r_min_idx   <= w_min_idx[TABLE_ENTRIES];
        end
        if (w_commit) begin
            r_slot   <= SLOT_W'(w_res_idx);
            r_status <= w_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_slot      = r_slot;
    assign o_status    = r_status;

`ifndef SYNTHESIS
    a_tail_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[TABLE_ENTRIES].valid |-> (r_state == S_SCAN))
        else $error("search token left the row outside the scan phase");

    a_write_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> ((r_state == S_DONE) && w_commit))
        else $error("table written outside a commit");

    a_commit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("commit did not present a result");

    a_untouched_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_status == ST_NOTFOUND) || (o_status == ST_ZEROCODE)))
            |-> (o_slot == '0))
        else $error("nonzero slot reported for an untouched table");
`endif

endmodule

// ===== rtl/ptmte_cell.sv =====
module ptmte_cell #(
    parameter int P_INDEX       = 0,
    parameter int IDX_W         = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptmte_pkg::t_scan   i_tok,
    input  logic [IDX_W-1:0]   i_match_idx,
    input  logic [IDX_W-1:0]   i_free_idx,
    input  logic [IDX_W-1:0]   i_min_idx,
    output ptmte_pkg::t_scan   o_tok,
    output logic [IDX_W-1:0]   o_match_idx,
    output logic [IDX_W-1:0]   o_free_idx,
    output logic [IDX_W-1:0]   o_min_idx,
    input  ptmte_pkg::t_wr     i_wr,
    input  logic [IDX_W-1:0]   i_wr_idx
);
    import ptmte_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(P_INDEX);

    logic [CODE_W-1:0] r_code;
    logic [TIME_W-1:0] r_time;
    t_scan             r_tok;
    logic [IDX_W-1:0]  r_match_idx;
    logic [IDX_W-1:0]  r_free_idx;
    logic [IDX_W-1:0]  r_min_idx;

    t_scan             n_tok;
    logic [IDX_W-1:0]  n_match_idx;
    logic [IDX_W-1:0]  n_free_idx;
    logic [IDX_W-1:0]  n_min_idx;

    // Fold this slot into the running match, free-slot and minimum results.
    always_comb begin
        n_tok       = i_tok;
        n_match_idx = i_match_idx;
        n_free_idx  = i_free_idx;
        n_min_idx   = i_min_idx;
        if (!i_tok.match_hit && (r_code == i_tok.code)) begin
            n_tok.match_hit = 1'b1;
            n_match_idx     = MY_IDX;
        end
        if (!i_tok.free_hit && (r_code == '0)) begin
            n_tok.free_hit = 1'b1;
            n_free_idx     = MY_IDX;
        end
        if ((P_INDEX == 0) || (r_time < i_tok.min_time)) begin
            n_tok.min_time = r_time;
            n_min_idx      = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok.code      <= n_tok.code;
        r_tok.match_hit <= n_tok.match_hit;
        r_tok.free_hit  <= n_tok.free_hit;
        r_tok.min_time  <= n_tok.min_time;
        r_match_idx     <= n_match_idx;
        r_free_idx      <= n_free_idx;
        r_min_idx       <= n_min_idx;
        if (!i_rst_n) begin
            r_code      <= '0;
            r_time      <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            if (i_wr.en && (i_wr_idx == MY_IDX)) begin
                r_code <= i_wr.code;
                r_time <= i_wr.run_time;
            end
            r_tok.valid <= n_tok.valid;
        end
    end

    assign o_tok       = r_tok;
    assign o_match_idx = r_match_idx;
    assign o_free_idx  = r_free_idx;
    assign o_min_idx   = r_min_idx;

endmodule
